/* rtl/core/ordered_array_list_engine_unit_macros.svh */
// Assertion macros for the ordered array list engine checkers.
`ifndef ORDERED_ARRAY_LIST_ENGINE_UNIT_MACROS_SVH
`define ORDERED_ARRAY_LIST_ENGINE_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define OAL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define OAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/oal_pkg.sv */
// Shared constants, types and codes for the ordered array list engine.
`default_nettype none
package oal_pkg;

    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = 8;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int FOUND_W  = 7;

    typedef logic [2:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_INSERT = 3'd0;
    localparam t_op OP_UPDATE = 3'd1;
    localparam t_op OP_DELETE = 3'd2;
    localparam t_op OP_SEARCH = 3'd3;
    localparam t_op OP_READ   = 3'd4;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_BAD_POS   = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;
    localparam t_status ST_BAD_OP    = 2'd3;

endpackage
`default_nettype wire

/* rtl/core/oal_ram.sv */
// Generic simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none
module oal_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

/* rtl/core/oal_ctrl.sv */
// Request sequencer: checks, shift/search sweeps over the RAM, result register.
`default_nettype none
module oal_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire oal_pkg::t_op                   i_operation,
    input  wire logic [oal_pkg::POS_W-1:0]      i_position,
    input  wire logic [oal_pkg::DATA_W-1:0]     i_item_value,
    output logic                                o_wr_en,
    output logic [oal_pkg::ADDR_W-1:0]          o_wr_addr,
    output logic [oal_pkg::DATA_W-1:0]          o_wr_data,
    output logic                                o_rd_en,
    output logic [oal_pkg::ADDR_W-1:0]          o_rd_addr,
    input  wire logic [oal_pkg::DATA_W-1:0]     i_rd_data,
    output logic                                o_done,
    output oal_pkg::t_status                    o_status,
    output logic [oal_pkg::FOUND_W-1:0]         o_found_index,
    output logic [oal_pkg::DATA_W-1:0]          o_read_value,
    output logic [oal_pkg::COUNT_W-1:0]         o_entry_count
);
    import oal_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_FINAL = 2'd2;

    localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAPACITY);

    logic [1:0]          r_state,   n_state;
    logic [COUNT_W-1:0]  r_count,   n_count;
    t_op                 r_op,      n_op;
    logic [ADDR_W-1:0]   r_pos,     n_pos;
    logic [DATA_W-1:0]   r_val,     n_val;
    logic [ADDR_W-1:0]   r_next,    n_next;
    logic [ADDR_W-1:0]   r_end,     n_end;
    logic                r_more,    n_more;
    logic                r_rd_pend, n_rd_pend;
    logic [ADDR_W-1:0]   r_rd_addr, n_rd_addr;
    logic                r_rd_last, n_rd_last;
    logic                r_done,    n_done;
    t_status             r_status,  n_status;
    logic [FOUND_W-1:0]  r_found,   n_found;
    logic [DATA_W-1:0]   r_rdata,   n_rdata;

    logic [COUNT_W-1:0]  pos_c;
    logic [COUNT_W-1:0]  count_m1;

    assign pos_c    = COUNT_W'(i_position);
    assign count_m1 = r_count - COUNT_W'(1);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_op      = r_op;
        n_pos     = r_pos;
        n_val     = r_val;
        n_next    = r_next;
        n_end     = r_end;
        n_more    = r_more;
        n_rd_pend = r_rd_pend;
        n_rd_addr = r_rd_addr;
        n_rd_last = r_rd_last;
        n_done    = 1'b0;
        n_status  = ST_OK;
        n_found   = '0;
        n_rdata   = '0;
        o_wr_en   = 1'b0;
        o_wr_addr = r_pos;
        o_wr_data = r_val;
        o_rd_en   = 1'b0;
        o_rd_addr = r_next;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op      = i_operation;
                    n_pos     = i_position[ADDR_W-1:0];
                    n_val     = i_item_value;
                    n_more    = 1'b1;
                    n_rd_pend = 1'b0;
                    n_rd_last = 1'b0;
                    unique case (i_operation)
                        OP_INSERT: begin
                            if (pos_c <= r_count && r_count < CAP_CNT) begin
                                if (pos_c == r_count) begin
                                    o_wr_en   = 1'b1;
                                    o_wr_addr = i_position[ADDR_W-1:0];
                                    o_wr_data = i_item_value;
                                    n_count   = r_count + COUNT_W'(1);
                                    n_done    = 1'b1;
                                end else begin
                                    n_next  = count_m1[ADDR_W-1:0];
                                    n_end   = i_position[ADDR_W-1:0];
                                    n_state = S_RUN;
                                end
                            end else begin
                                n_done   = 1'b1;
                                n_status = ST_BAD_POS;
                            end
                        end
                        OP_UPDATE: begin
                            n_done = 1'b1;
                            if (pos_c < r_count) begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = i_position[ADDR_W-1:0];
                                o_wr_data = i_item_value;
                            end else begin
                                n_status = ST_BAD_POS;
                            end
                        end
                        OP_DELETE: begin
                            if (pos_c < r_count) begin
                                if (pos_c == count_m1) begin
                                    n_count = count_m1;
                                    n_done  = 1'b1;
                                end else begin
                                    n_next  = i_position[ADDR_W-1:0] + ADDR_W'(1);
                                    n_end   = count_m1[ADDR_W-1:0];
                                    n_state = S_RUN;
                                end
                            end else begin
                                n_done   = 1'b1;
                                n_status = ST_BAD_POS;
                            end
                        end
                        OP_SEARCH: begin
                            if (r_count == '0) begin
                                n_done   = 1'b1;
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_next  = '0;
                                n_end   = count_m1[ADDR_W-1:0];
                                n_state = S_RUN;
                            end
                        end
                        OP_READ: begin
                            if (pos_c < r_count) begin
                                n_next  = i_position[ADDR_W-1:0];
                                n_end   = i_position[ADDR_W-1:0];
                                n_state = S_RUN;
                            end else begin
                                n_done   = 1'b1;
                                n_status = ST_BAD_POS;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = ST_BAD_OP;
                        end
                    endcase
                end
            end
            S_RUN: begin
                // issue the next sweep read while consuming the previous one
                o_rd_en   = r_more;
                o_rd_addr = r_next;
                n_more    = r_more && (r_next != r_end);
                n_next    = (r_op == OP_INSERT) ? r_next - ADDR_W'(1) : r_next + ADDR_W'(1);
                n_rd_pend = r_more;
                n_rd_addr = r_next;
                n_rd_last = r_more && (r_next == r_end);
                if (r_rd_pend) begin
                    unique case (r_op)
                        OP_INSERT: begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = r_rd_addr + ADDR_W'(1);
                            o_wr_data = i_rd_data;
                            if (r_rd_last) begin
                                n_state = S_FINAL;
                            end
                        end
                        OP_DELETE: begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = r_rd_addr - ADDR_W'(1);
                            o_wr_data = i_rd_data;
                            if (r_rd_last) begin
                                n_count = count_m1;
                                n_done  = 1'b1;
                                n_state = S_IDLE;
                            end
                        end
                        OP_SEARCH: begin
                            if (i_rd_data == r_val) begin
                                n_found = FOUND_W'(r_rd_addr);
                                n_done  = 1'b1;
                                n_state = S_IDLE;
                            end else if (r_rd_last) begin
                                n_status = ST_NOT_FOUND;
                                n_done   = 1'b1;
                                n_state  = S_IDLE;
                            end
                        end
                        default: begin
                            n_rdata = i_rd_data;
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_FINAL: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_pos;
                o_wr_data = r_val;
                n_count   = r_count + COUNT_W'(1);
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_more    <= 1'b0;
            r_rd_pend <= 1'b0;
            r_rd_last <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_more    <= n_more;
            r_rd_pend <= n_rd_pend;
            r_rd_last <= n_rd_last;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_next    <= n_next;
        r_end     <= n_end;
        r_rd_addr <= n_rd_addr;
        r_status  <= n_status;
        r_found   <= n_found;
        r_rdata   <= n_rdata;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found_index = r_found;
    assign o_read_value  = r_rdata;
    assign o_entry_count = r_count;

endmodule
`default_nettype wire

/* rtl/core/ordered_array_list_engine_unit.sv */
// Top level of the ordered array list engine: sequencer plus entry RAM.
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with o_done high, and cannot be held off by the
// receiver. Refused requests, update, insert at the end and delete of the last
// entry finish straight from idle, with the result in the next cycle. Read,
// search, insert at position p and delete at p instead run a sweep: the shift
// and search sweeps move one entry per cycle through the single read and single
// write port of the entry RAM, reading one address ahead of the write. busy is
// high for the whole sweep. The list resets empty.
`default_nettype none
module ordered_array_list_engine_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [2:0]                        i_operation,
    input  wire logic [oal_pkg::POS_W-1:0]         i_position,
    input  wire logic signed [oal_pkg::DATA_W-1:0] i_item_value,
    output logic                                   o_done,
    output logic [1:0]                             o_status,
    output logic [oal_pkg::FOUND_W-1:0]            o_found_index,
    output logic signed [oal_pkg::DATA_W-1:0]      o_read_value,
    output logic [oal_pkg::COUNT_W-1:0]            o_entry_count
);
    import oal_pkg::*;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [DATA_W-1:0]   rd_data;
    logic [DATA_W-1:0]   read_value;

    oal_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_read_value  (read_value),
        .o_entry_count (o_entry_count)
    );

    oal_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_read_value = signed'(read_value);

endmodule
`default_nettype wire

/* rtl/core/oal_chk.sv */
// Port-level checker for the ordered array list engine, bound to the top level.
`default_nettype none
`include "ordered_array_list_engine_unit_macros.svh"
module oal_chk (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic                              o_done,
    input wire logic [1:0]                        o_status,
    input wire logic [oal_pkg::FOUND_W-1:0]       o_found_index,
    input wire logic signed [oal_pkg::DATA_W-1:0] o_read_value,
    input wire logic [oal_pkg::COUNT_W-1:0]       o_entry_count
);
    import oal_pkg::*;

    `OAL_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_done, "accepted item neither in progress nor finished")
    `OAL_ASSERT_SAME(a_done_has_item, i_clk, i_rst_n, o_done, $past(start) || $past(busy), "result without an item")
    `OAL_ASSERT_SAME(a_busy_ends_done, i_clk, i_rst_n, $fell(busy), o_done, "sweep ended without a result")
    `OAL_ASSERT_SAME(a_count_stable, i_clk, i_rst_n, !o_done, $stable(o_entry_count), "entry count moved without a result")
    `OAL_ASSERT_SAME(a_refused_zero, i_clk, i_rst_n, o_done && o_status != ST_OK, o_found_index == '0 && o_read_value == '0, "refused item carries data")

endmodule

bind ordered_array_list_engine_unit oal_chk u_oal_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_found_index (o_found_index),
    .o_read_value  (o_read_value),
    .o_entry_count (o_entry_count)
);
`default_nettype wire
